@@ rtl/core/uam_pkg.sv @@
// Shared constants and types for the unsorted array max queue.
package uam_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int VW    = 32;
	localparam int CAPW  = 7;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_REM = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_SHIFT = 3'b100
	} state_t;

endpackage

@@ rtl/core/unsorted_array_max_queue.sv @@
// Top level: bounded insertion-order store with remove-max and running minimum.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  request  | start, busy            | func, value
//  result   | done (1-cycle strobe)  | status, removed_value, count, min_value
//  config   | cfg_valid, cfg_ready   | cfg_data (capacity)
//
// Add, refused add and remove on empty finish from idle: done rises in the cycle after
// the accept. Remove-max makes one pass over the array to find the max, then a second
// from its position shifting later entries down; done rises when the shift pass ends.
// Reset clears count, capacity (to 64) and control; array contents are not cleared.
// The result strobe cannot be held off; the next request may start in the done cycle.
module unsorted_array_max_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      func,
	input  logic [uam_pkg::VW-1:0]    value,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [uam_pkg::CAPW-1:0]  cfg_data,
	output logic                      done,
	output logic [1:0]                status,
	output logic [uam_pkg::VW-1:0]    removed_value,
	output logic [uam_pkg::CW-1:0]    count,
	output logic [uam_pkg::VW-1:0]    min_value
);
	import uam_pkg::*;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [CAPW-1:0] cap_q;
	logic [VW-1:0]   min_q;

	logic [VW-1:0]   mem [DEPTH];
	logic [VW-1:0]   rdata_s1;
	logic            rv_s1;
	logic [AW-1:0]   ri_s1;

	logic [CW-1:0]   iss_q;
	logic [VW-1:0]   best_q;
	logic [AW-1:0]   pos_q;
	logic [VW-1:0]   run_min_q;
	logic [VW-1:0]   pre_min_q;
	logic            pre_has_q;
	logic [VW-1:0]   post_min_q;
	logic            post_has_q;

	logic            done_q;
	logic [1:0]      status_q;
	logic [VW-1:0]   removed_q;
	logic [VW-1:0]   min_out_q;

	logic            accept;
	logic            full;
	logic [CW-1:0]   eff_cap;
	logic            issuing;
	logic            first;
	logic            take;
	logic            last;
	logic [AW-1:0]   pos_next;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [VW-1:0]   wdata;
	logic [VW-1:0]   add_min;
	logic [VW-1:0]   fin_min;
	logic            shift_end;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;

	assign eff_cap = (CW'(cap_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
	assign full    = (cnt_q >= eff_cap);

	assign issuing = (state_q == S_SCAN || state_q == S_SHIFT) && (iss_q < cnt_q);

	// scan compare: earliest largest wins, so only a strictly greater entry replaces
	assign first    = (ri_s1 == '0);
	assign take     = first || ($signed(rdata_s1) > $signed(best_q));
	assign last     = ({1'b0, ri_s1} == CW'(cnt_q - CW'(1)));
	assign pos_next = take ? ri_s1 : pos_q;

	assign add_min = (cnt_q == '0 || $signed(value) < $signed(min_q)) ? value : min_q;

	assign shift_end = (state_q == S_SHIFT) && !issuing && !rv_s1;

	// min of what is left: entries before the max plus entries after it
	always_comb begin
		if (pre_has_q && post_has_q) begin
			fin_min = ($signed(pre_min_q) < $signed(post_min_q)) ? pre_min_q : post_min_q;
		end else if (pre_has_q) begin
			fin_min = pre_min_q;
		end else if (post_has_q) begin
			fin_min = post_min_q;
		end else begin
			fin_min = '0;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = value;
		if (state_q == S_IDLE) begin
			we = accept && (func == FUNC_ADD) && !full;
		end else if (state_q == S_SHIFT && rv_s1) begin
			we    = 1'b1;
			waddr = ri_s1 - AW'(1);
			wdata = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[iss_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPW'(DEPTH);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// scan and shift datapath plus result registers, no reset needed
	always_ff @(posedge clk) begin
		ri_s1 <= iss_q[AW-1:0];
		if (state_q == S_SCAN && rv_s1) begin
			if (take) begin
				best_q    <= rdata_s1;
				pos_q     <= ri_s1;
				pre_min_q <= run_min_q;
			end
			if (first || $signed(rdata_s1) < $signed(run_min_q)) begin
				run_min_q <= rdata_s1;
			end
		end
		if (state_q == S_SHIFT && rv_s1) begin
			if (!post_has_q || $signed(rdata_s1) < $signed(post_min_q)) begin
				post_min_q <= rdata_s1;
			end
		end
		removed_q <= '0;
		min_out_q <= min_q;
		status_q  <= ST_DONE;
		if (state_q == S_IDLE && accept) begin
			if (func == FUNC_ADD) begin
				status_q <= full ? ST_FULL : ST_DONE;
				if (!full) begin
					min_out_q <= add_min;
				end
			end else if (cnt_q == '0) begin
				status_q  <= ST_EMPTY;
				min_out_q <= '0;
			end
		end
		if (shift_end) begin
			removed_q <= best_q;
			min_out_q <= fin_min;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			min_q      <= '0;
			iss_q      <= '0;
			rv_s1      <= 1'b0;
			pre_has_q  <= 1'b0;
			post_has_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rv_s1  <= issuing;
			if (issuing) begin
				iss_q <= iss_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FUNC_ADD) begin
							done_q <= 1'b1;
							if (!full) begin
								cnt_q <= cnt_q + CW'(1);
								min_q <= add_min;
							end
						end else if (cnt_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_SCAN;
							iss_q   <= '0;
						end
					end
				end
				S_SCAN: begin
					if (rv_s1) begin
						if (take) begin
							pre_has_q <= !first;
						end
						if (last) begin
							state_q    <= S_SHIFT;
							iss_q      <= CW'({1'b0, pos_next}) + CW'(1);
							post_has_q <= 1'b0;
						end
					end
				end
				S_SHIFT: begin
					if (rv_s1) begin
						post_has_q <= 1'b1;
					end
					if (shift_end) begin
						state_q <= S_IDLE;
						cnt_q   <= cnt_q - CW'(1);
						min_q   <= fin_min;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign count         = cnt_q;
	assign min_value     = min_out_q;

endmodule

@@ rtl/core/uam_checker.sv @@
// Port-level checks for the unsorted array max queue, bound to the top level.
module uam_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      func,
	input  logic [uam_pkg::VW-1:0]    value,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [uam_pkg::CAPW-1:0]  cfg_data,
	input  logic                      done,
	input  logic [1:0]                status,
	input  logic [uam_pkg::VW-1:0]    removed_value,
	input  logic [uam_pkg::CW-1:0]    count,
	input  logic [uam_pkg::VW-1:0]    min_value
);
	import uam_pkg::*;

	// an add request always answers on the next edge
	a_add_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_ADD |=> done && !busy)
		else $error("add request did not complete in one cycle");

	// a remove request either answers at once or keeps the block busy
	a_rem_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_REM |=> done || busy)
		else $error("remove request lost");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		done && count == '0 |-> min_value == '0)
		else $error("empty store reports nonzero minimum");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EMPTY |-> count == '0 && removed_value == '0)
		else $error("empty status with stored entries or removed value");

endmodule

bind unsorted_array_max_queue uam_checker u_uam_checker (.*);

@@ tb/tb_unsorted_array_max_queue.sv @@
// Self-checking testbench for the unsorted array max queue: directed, capacity and random traffic.
module tb_unsorted_array_max_queue;
	import uam_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [1:0]    status;
		logic [VW-1:0] removed;
		logic [CW-1:0] count;
		logic [VW-1:0] min_value;
	} result_t;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic            func;
	logic [VW-1:0]   value;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [CAPW-1:0] cfg_data;
	logic            done;
	logic [1:0]      status;
	logic [VW-1:0]   removed_value;
	logic [CW-1:0]   count;
	logic [VW-1:0]   min_value;

	logic signed [VW-1:0] held_values[$];
	result_t              pending_results[$];
	int                   cap_setting;
	int                   errors;
	int                   stall_cycles;
	bit                   sender_gaps;

	unsorted_array_max_queue u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.removed_value(removed_value),
		.count(count),
		.min_value(min_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Predicts one operation against the held copy of the store.
	function automatic result_t apply_queue_op(logic op, logic [VW-1:0] v);
		result_t              r;
		int                   lim;
		int                   pos;
		logic signed [VW-1:0] lo;
		r = '0;
		lim = (cap_setting > DEPTH) ? DEPTH : cap_setting;
		if (op == FUNC_ADD) begin
			if (held_values.size() >= lim)
				r.status = ST_FULL;
			else
				held_values.push_back(v);
		end else if (held_values.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			// strict compare keeps the earliest of tied maxima
			pos = 0;
			for (int i = 1; i < held_values.size(); i++)
				if (held_values[i] > held_values[pos])
					pos = i;
			r.removed = held_values[pos];
			held_values.delete(pos);
		end
		r.count = CW'(held_values.size());
		lo = '0;
		if (held_values.size() > 0) begin
			lo = held_values[0];
			foreach (held_values[i])
				if (held_values[i] < lo)
					lo = held_values[i];
		end
		r.min_value = lo;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [VW-1:0] got,
			input logic [VW-1:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic send_request(input logic op, input logic [VW-1:0] v);
		start <= 1'b1;
		func  <= op;
		value <= v;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_queue_op(op, v));
		if (sender_gaps && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Drops start, waits out every outstanding request, then idles before returning.
	task automatic settle_idle();
		if (start)
			start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input int c);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= c[CAPW-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_setting = c;
	endtask

	function automatic logic [VW-1:0] rand_value();
		logic [VW-1:0] v;
		case ($urandom_range(0, 3))
			0: case ($urandom_range(0, 3))
				0: v = 32'h8000_0000;
				1: v = 32'h7fff_ffff;
				2: v = '0;
				default: v = '1;
			endcase
			1: v = $urandom_range(0, 8) - 4;  // narrow range makes ties likely
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic test_empty_and_extremes();
		send_request(FUNC_REM, 32'h1234_5678);
		send_request(FUNC_ADD, 32'h7fff_ffff);
		send_request(FUNC_ADD, 32'h8000_0000);
		send_request(FUNC_ADD, 32'h0000_0000);
		send_request(FUNC_ADD, 32'hffff_ffff);
		send_request(FUNC_ADD, 32'h7fff_ffff);
		repeat (5)
			send_request(FUNC_REM, 32'hffff_ffff);
		send_request(FUNC_REM, 32'h0);
		settle_idle();
	endtask

	task automatic test_capacity_limits();
		write_capacity(0);
		send_request(FUNC_ADD, 32'd5);
		send_request(FUNC_REM, 32'd0);
		write_capacity(1);
		send_request(FUNC_ADD, 32'd9);
		send_request(FUNC_ADD, 32'd10);
		send_request(FUNC_REM, 32'd0);
		write_capacity(127);
		for (int i = 1; i <= 4; i++)
			send_request(FUNC_ADD, i);
		// capacity below the current count: adds refused, removes still work
		write_capacity(2);
		send_request(FUNC_ADD, 32'd7);
		send_request(FUNC_REM, 32'd0);
		send_request(FUNC_REM, 32'd0);
		send_request(FUNC_ADD, 32'd8);
		send_request(FUNC_REM, 32'd0);
	endtask

	task automatic test_random_traffic();
		int caps[8]    = '{64, 127, 3, 1, 0, 17, 100, 64};
		int add_pct[8] = '{55, 92, 60, 50, 50, 70, 90, 40};
		int items[8]   = '{60, 90, 50, 50, 30, 60, 90, 70};
		for (int p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			sender_gaps = (p != 7) && (p != 3);
			for (int n = 0; n < items[p]; n++)
				send_request(($urandom_range(1, 100) <= add_pct[p]) ? FUNC_ADD : FUNC_REM,
					rand_value());
		end
		write_capacity($urandom_range(1, 127));
		settle_idle();
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", VW'(status), '0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", VW'(status), VW'(want.status));
				if (removed_value !== want.removed)
					report_mismatch("removed_value", removed_value, want.removed);
				if (count !== want.count)
					report_mismatch("count", VW'(count), VW'(want.count));
				if (min_value !== want.min_value)
					report_mismatch("min_value", min_value, want.min_value);
			end
		end
	end

	// Longest correct gap is a remove over a full store plus a sender burst.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("unsorted_array_max_queue verification failed");
			$finish;
		end
	end

	initial begin
		start        <= 1'b0;
		func         <= FUNC_ADD;
		value        <= '0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		arst_n       <= 1'b0;
		errors      = 0;
		cap_setting = 64;
		sender_gaps = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_extremes();
		test_capacity_limits();
		test_random_traffic();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), '0);
		if (errors == 0)
			$display("unsorted_array_max_queue verification clean");
		else
			$display("unsorted_array_max_queue verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/uam_pkg.sv
rtl/core/unsorted_array_max_queue.sv
rtl/core/uam_checker.sv
tb/tb_unsorted_array_max_queue.sv
